// File: rtl/msc_pkg.sv
// shared types and constants for the mic sample conditioning block
// no dependencies; used by msc_hpf, msc_blk and mic_sample_conditioning_top
`timescale 1ns / 1ps

package msc_pkg;

    // sample and register widths
    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 15;
    localparam int WARMUP_W  = 16;
    localparam int GAIN_W    = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W    = 8;

    // i2s word layout: sample sits in bits 29..14
    localparam int I2S_W      = 32;
    localparam int I2S_LSB    = 14;

    // block length is a power of two so the average is a plain shift
    localparam int BLOCK_LOG2 = 7;
    localparam int BLOCK_LEN  = 1 << BLOCK_LOG2;
    localparam int SUM_W      = BLOCK_LOG2 + SAMPLE_W;

    // reset values of the configuration registers
    localparam logic [COEFF_W-1:0]  HPF_COEFF_RST = 15'd32604;
    localparam logic [WARMUP_W-1:0] WARMUP_RST    = 16'd10000;
    localparam logic [GAIN_W-1:0]   GAIN_RST      = 4'd4;

    // register index codes
    localparam logic [CFG_IDX_W-1:0] CFG_HPF_COEFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

    // saturation limits of the filter output
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // rounding bias for the q15 feedback product (1 << 14)
    localparam logic signed [31:0] FB_ROUND = 32'sd16384;

    typedef struct packed {
        logic [COEFF_W-1:0]  hpf_coeff;
        logic [WARMUP_W-1:0] warmup_samples;
        logic [GAIN_W-1:0]   gain;
    } cfg_t;

endpackage

// File: rtl/msc_hpf.sv
// input register and dc-blocking high-pass filter stage with warm-up drop
// depends on msc_pkg
`timescale 1ns / 1ps

module msc_hpf (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [msc_pkg::I2S_W-1:0]      i2s_word,
    input  msc_pkg::cfg_t                         cfg,
    output logic                                  y_valid,
    input  logic                                  y_ready,
    output logic signed [msc_pkg::SAMPLE_W-1:0]   y
);

    logic                                 x_valid_reg;
    logic signed [msc_pkg::SAMPLE_W-1:0]  x_reg;
    logic signed [msc_pkg::SAMPLE_W-1:0]  prev_in_reg;
    logic signed [msc_pkg::SAMPLE_W-1:0]  prev_out_reg;
    logic [msc_pkg::WARMUP_W-1:0]         warmup_count_reg;
    logic [msc_pkg::WARMUP_W-1:0]         warmup_count_next;
    logic                                 y_valid_reg;
    logic signed [msc_pkg::SAMPLE_W-1:0]  y_reg;

    logic                                 filt_ready;
    logic                                 filt_fire;
    logic                                 keep;
    logic signed [31:0]                   fb_prod;
    logic signed [31:0]                   fb_shift;
    logic signed [18:0]                   raw_sum;
    logic signed [msc_pkg::SAMPLE_W-1:0]  y_new;

    assign filt_ready = !y_valid_reg || y_ready;
    assign filt_fire  = x_valid_reg && filt_ready;
    assign in_ready   = !x_valid_reg || filt_ready;
    assign keep       = warmup_count_reg >= cfg.warmup_samples;

    // y = x - x_prev + round(coeff * y_prev / 2^15), saturated
    always_comb
    begin
        fb_prod  = $signed({1'b0, cfg.hpf_coeff}) * prev_out_reg;
        fb_shift = (fb_prod + msc_pkg::FB_ROUND) >>> 15;
        raw_sum  = 19'(x_reg) - 19'(prev_in_reg) + 19'($signed(fb_shift[16:0]));
        if (raw_sum > 19'(msc_pkg::SAT_MAX))
            y_new = msc_pkg::SAT_MAX;
        else if (raw_sum < 19'(msc_pkg::SAT_MIN))
            y_new = msc_pkg::SAT_MIN;
        else
            y_new = raw_sum[msc_pkg::SAMPLE_W-1:0];
    end

    assign warmup_count_next = (filt_fire && !keep) ? warmup_count_reg + 1'b1
                                                    : warmup_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg      <= 1'b0;
            y_valid_reg      <= 1'b0;
            prev_in_reg      <= '0;
            prev_out_reg     <= '0;
            warmup_count_reg <= '0;
        end
        else
        begin
            if (in_ready)
                x_valid_reg <= in_valid;
            if (filt_ready)
                y_valid_reg <= filt_fire && keep;
            if (filt_fire)
            begin
                prev_in_reg  <= x_reg;
                prev_out_reg <= y_new;
            end
            warmup_count_reg <= warmup_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            x_reg <= i2s_word[msc_pkg::I2S_LSB+msc_pkg::SAMPLE_W-1:msc_pkg::I2S_LSB];
        if (filt_fire && keep)
            y_reg <= y_new;
    end

    assign y_valid = y_valid_reg;
    assign y       = y_reg;

endmodule

// File: rtl/msc_blk.sv
// output scaling, block absolute-level accumulator and result register
// depends on msc_pkg
`timescale 1ns / 1ps

module msc_blk (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 y_valid,
    output logic                                 y_ready,
    input  logic signed [msc_pkg::SAMPLE_W-1:0]  y,
    input  logic [msc_pkg::GAIN_W-1:0]           gain,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [msc_pkg::BYTE_W-1:0]           sample_byte,
    output logic                                 block_end,
    output logic [msc_pkg::SAMPLE_W-1:0]         block_average
);

    localparam logic [msc_pkg::BLOCK_LOG2-1:0] POS_LAST =
        msc_pkg::BLOCK_LOG2'(msc_pkg::BLOCK_LEN - 1);

    logic                                 out_valid_reg;
    logic [msc_pkg::BYTE_W-1:0]           byte_reg;
    logic                                 block_end_reg;
    logic [msc_pkg::SAMPLE_W-1:0]         avg_reg;
    logic [msc_pkg::BLOCK_LOG2-1:0]       pos_reg;
    logic [msc_pkg::SUM_W-1:0]            sum_reg;

    logic                                 fire;
    logic                                 last;
    logic signed [20:0]                   scaled;
    logic signed [20:0]                   biased;
    logic [msc_pkg::SAMPLE_W-1:0]         mag;
    logic [msc_pkg::SUM_W-1:0]            total;

    assign y_ready = !out_valid_reg || out_ready;
    assign fire    = y_valid && y_ready;
    assign last    = pos_reg == POS_LAST;

    always_comb
    begin
        scaled = y * $signed({1'b0, gain});
        // truncate toward zero: bias negatives by 255 before the shift
        biased = scaled + (scaled[20] ? 21'sd255 : 21'sd0);
        mag    = y[msc_pkg::SAMPLE_W-1] ? (~y + 1'b1) : y;
        total  = sum_reg + msc_pkg::SUM_W'(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (y_ready)
                out_valid_reg <= y_valid;
            if (fire)
            begin
                pos_reg <= pos_reg + 1'b1;
                sum_reg <= last ? '0 : total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            byte_reg      <= biased[msc_pkg::BYTE_W+7:8];
            block_end_reg <= last;
            avg_reg       <= last ? total[msc_pkg::SUM_W-1 -: msc_pkg::SAMPLE_W] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_byte   = byte_reg;
    assign block_end     = block_end_reg;
    assign block_average = avg_reg;

    a_avg_zero_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !block_end_reg |-> avg_reg == '0)
        else $error("block average nonzero outside block end");

    a_request_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("accepted sample did not reach the result register");

    a_block_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last |=> block_end_reg && pos_reg == '0 && sum_reg == '0)
        else $error("block did not close on its last sample");

    a_mid_block_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last |=> !block_end_reg && pos_reg == $past(pos_reg) + 1'b1)
        else $error("block position did not advance");

endmodule

// File: rtl/mic_sample_conditioning_top.sv
// mic sample conditioning block: dc-blocking high-pass, warm-up drop, output
// byte scaling and per-block mean absolute level
// depends on msc_pkg, msc_hpf, msc_blk
//
// usage
//   input request: in_valid/in_ready with one 32-bit i2s word; the sample is
//   taken from bits 29..14. output request: out_valid/out_ready with
//   sample_byte, block_end and block_average (nonzero only when block_end).
//   configuration: cfg_write with cfg_index/cfg_data, taken at the clock edge;
//   index 0 hpf coefficient, 1 warm-up sample count, 2 gain, 3 ignored.
//   write configuration only while no sample is in flight.
// timing
//   three register stages: input register, filter register, result register.
//   kept samples pass input, filter, result register in turn. one sample per
//   cycle holds while out_ready is high; feedback multiply is in filter stage.
//   samples dropped during warm-up advance the filter but give no result.
// reset
//   filter history, warm-up count and block sum clear; registers take their
//   default values. when out_ready is low the stages fill one by one and
//   in_ready drops only once all three hold a sample.
`timescale 1ns / 1ps

module mic_sample_conditioning_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [msc_pkg::I2S_W-1:0]        i2s_word,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [msc_pkg::BYTE_W-1:0]              sample_byte,
    output logic                                    block_end,
    output logic [msc_pkg::SAMPLE_W-1:0]            block_average,
    input  logic                                    cfg_write,
    input  logic [msc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]          cfg_data
);

    msc_pkg::cfg_t                        cfg_reg;
    logic                                 y_valid;
    logic                                 y_ready;
    logic signed [msc_pkg::SAMPLE_W-1:0]  y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hpf_coeff      <= msc_pkg::HPF_COEFF_RST;
            cfg_reg.warmup_samples <= msc_pkg::WARMUP_RST;
            cfg_reg.gain           <= msc_pkg::GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                msc_pkg::CFG_HPF_COEFF:
                    cfg_reg.hpf_coeff <= cfg_data[msc_pkg::COEFF_W-1:0];
                msc_pkg::CFG_WARMUP:
                    cfg_reg.warmup_samples <= cfg_data[msc_pkg::WARMUP_W-1:0];
                msc_pkg::CFG_GAIN:
                    cfg_reg.gain <= cfg_data[msc_pkg::GAIN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    msc_hpf u_hpf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .i2s_word (i2s_word),
        .cfg      (cfg_reg),
        .y_valid  (y_valid),
        .y_ready  (y_ready),
        .y        (y)
    );

    msc_blk u_blk (
        .clk           (clk),
        .rst_n         (rst_n),
        .y_valid       (y_valid),
        .y_ready       (y_ready),
        .y             (y),
        .gain          (cfg_reg.gain),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_byte   (sample_byte),
        .block_end     (block_end),
        .block_average (block_average)
    );

endmodule
